/* hw/rtl/fbpa_pkg.sv */
// Package for the fixed block pool allocator: widths, codes and payload types.
// Used by every RTL file of the block except fbpa_ram; depends on nothing.
`default_nettype none

package fbpa_pkg;

  // Pool geometry
  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = IdxW + 1;

  // Field widths fixed by the interface
  localparam int unsigned OffW      = 32;
  localparam int unsigned SizeW     = 32;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned PoolW     = 11;
  localparam int unsigned HdrW      = 13;
  localparam int unsigned StrideW   = 17;
  localparam int unsigned CfgW      = 17;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned StatusW   = 2;

  // Derived datapath widths
  localparam int unsigned MulW      = CntW + StrideW;
  localparam int unsigned CmpW      = (OffW > MulW) ? OffW : MulW;
  localparam int unsigned PoolCmpW  = (PoolW > CntW) ? PoolW : CntW;
  localparam int unsigned DivCycles = (IdxW + 1) / 2;
  localparam int unsigned DivSteps  = 2 * DivCycles;
  localparam int unsigned DivCntW   = $clog2(DivCycles + 1);
  localparam int unsigned RemW      = StrideW + DivSteps;
  localparam int unsigned GrantW    = MulW + 1;
  localparam int unsigned RamW      = IdxW + 1;

  // Command codes
  typedef enum logic [1:0] {
    CmdAlloc = 2'd0,
    CmdFree  = 2'd1,
    CmdReset = 2'd2
  } fbpa_cmd_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StRange     = 2'd1,
    StDouble    = 2'd2,
    StAllocFail = 2'd3
  } fbpa_status_e;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgBlockLimit  = 2'd0,
    CfgBlocksInUse = 2'd1,
    CfgHeaderBytes = 2'd2,
    CfgStrideBytes = 2'd3
  } fbpa_cfg_e;

  // Classified operation kinds passed from front to back
  typedef enum logic [2:0] {
    KindNop      = 3'd0,
    KindAlloc    = 3'd1,
    KindOversize = 3'd2,
    KindFree     = 3'd3,
    KindReset    = 3'd4
  } fbpa_kind_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [SizeW-1:0] request_size;
    logic [OffW-1:0]  payload_offset;
  } fbpa_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [OffW-1:0]    granted_offset;
    logic [PoolW-1:0]   used_blocks;
    logic [PoolW-1:0]   free_blocks;
    logic [PoolW-1:0]   peak_blocks;
  } fbpa_res_t;

  typedef struct packed {
    logic [LimitW-1:0]  block_limit;
    logic [PoolW-1:0]   blocks_in_use;
    logic [HdrW-1:0]    header_bytes;
    logic [StrideW-1:0] stride_bytes;
  } fbpa_cfg_t;

  typedef struct packed {
    fbpa_kind_e      kind;
    logic [OffW-1:0] offset;
  } fbpa_op_t;

endpackage

`default_nettype wire

/* hw/rtl/fbpa_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module fbpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/fbpa_front.sv */
// Front end: takes request items, classifies them and holds them in a 2-entry queue.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire fbpa_pkg::fbpa_req_t          req_i,
  input  wire logic [fbpa_pkg::LimitW-1:0]  limit_i,
  output logic                              op_valid_o,
  output fbpa_pkg::fbpa_op_t                op_o,
  input  wire logic                         op_take_i
);

  localparam int unsigned QDepth = 2;

  fbpa_pkg::fbpa_op_t op_new;
  fbpa_pkg::fbpa_op_t slot_q [QDepth];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               accept;

  // Classify the incoming item
  always_comb begin
    op_new.offset = req_i.payload_offset;
    op_new.kind   = fbpa_pkg::KindNop;
    case (req_i.command)
      fbpa_pkg::CmdAlloc: begin
        if (req_i.request_size > fbpa_pkg::SizeW'(limit_i)) begin
          op_new.kind = fbpa_pkg::KindOversize;
        end else begin
          op_new.kind = fbpa_pkg::KindAlloc;
        end
      end
      fbpa_pkg::CmdFree:  op_new.kind = fbpa_pkg::KindFree;
      fbpa_pkg::CmdReset: op_new.kind = fbpa_pkg::KindReset;
      default:            op_new.kind = fbpa_pkg::KindNop;
    endcase
  end

  assign full       = (count_q == 2'(QDepth));
  assign accept     = push & ~full;
  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = slot_q[rd_ptr_q];

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = op_take_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(accept) - 2'(op_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fbpa_back.sv */
// Back end: free list engine with link RAM, offset divider and result register.
// Depends on fbpa_pkg and fbpa_ram.
`default_nettype none

module fbpa_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fbpa_pkg::fbpa_cfg_t cfg_i,
  input  wire logic                op_valid_i,
  input  wire fbpa_pkg::fbpa_op_t  op_i,
  output logic                     op_take_o,
  output logic                     out_valid_o,
  output fbpa_pkg::fbpa_res_t      res_o,
  input  wire logic                out_ready_i
);

  localparam int unsigned IdxW = fbpa_pkg::IdxW;
  localparam int unsigned CntW = fbpa_pkg::CntW;

  // Sequencer states
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SArd  = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SChk  = 3'd3;
  localparam logic [2:0] SDiv  = 3'd4;
  localparam logic [2:0] SQchk = 3'd5;
  localparam logic [2:0] SFrd  = 3'd6;
  localparam logic [2:0] SFin  = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic [IdxW-1:0]                head_q, head_d;
  logic [CntW-1:0]                wm_q, wm_d;
  logic [CntW-1:0]                alloc_q, alloc_d;
  logic [CntW-1:0]                peak_q, peak_d;
  logic [CntW-1:0]                pool_q, pool_d;
  logic [fbpa_pkg::DivCntW-1:0]   dcnt_q, dcnt_d;
  logic                           out_valid_q, out_valid_d;

  fbpa_pkg::fbpa_op_t             op_q, op_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic [fbpa_pkg::MulW-1:0]      prod_q, prod_d;
  logic [fbpa_pkg::RemW-1:0]      rem_q, rem_d;
  logic [fbpa_pkg::RemW-1:0]      dsh_q, dsh_d;
  logic [fbpa_pkg::DivSteps-1:0]  quo_q, quo_d;
  logic [fbpa_pkg::StatusW-1:0]   status_q, status_d;
  logic                           grant_q, grant_d;
  fbpa_pkg::fbpa_res_t            res_q, res_d;

  logic [fbpa_pkg::StrideW-1:0]   stride_eff;
  logic [CntW-1:0]                pool_sat;
  logic [CntW-1:0]                mul_a;
  logic [fbpa_pkg::MulW-1:0]      mul_p;
  logic                           list_empty;
  logic                           fresh;
  logic                           out_free;
  logic [IdxW-1:0]                quo_idx;
  logic [fbpa_pkg::GrantW-1:0]    grant_sum;
  logic                           b_hi, b_lo;
  logic [fbpa_pkg::RemW-1:0]      rem_a, rem_b, dsh_b;

  logic                           ram_we;
  logic [IdxW-1:0]                ram_waddr;
  logic [fbpa_pkg::RamW-1:0]      ram_wdata;
  logic [IdxW-1:0]                ram_raddr;
  logic [fbpa_pkg::RamW-1:0]      ram_rdata;

  // Link RAM: top bit marks a block in use, low bits hold the next link.
  // Entries at or above the watermark were not touched since the last rebuild.
  fbpa_ram #(
    .Width (fbpa_pkg::RamW),
    .Depth (fbpa_pkg::MaxBlocks)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Layout helpers
  assign stride_eff = (cfg_i.stride_bytes == '0) ? fbpa_pkg::StrideW'(1) : cfg_i.stride_bytes;
  assign pool_sat   = (fbpa_pkg::PoolCmpW'(cfg_i.blocks_in_use) >
                       fbpa_pkg::PoolCmpW'(fbpa_pkg::MaxBlocks)) ?
                      CntW'(fbpa_pkg::MaxBlocks) : CntW'(cfg_i.blocks_in_use);
  assign list_empty = (alloc_q >= pool_q);
  assign fresh      = (CntW'(head_q) >= wm_q);
  assign quo_idx    = quo_q[IdxW-1:0];
  assign out_free   = ~out_valid_q | out_ready_i;
  assign ram_raddr  = (state_q == SIdle) ? head_q : quo_idx;

  // Shared multiplier: block index or pool size times stride
  assign mul_a = (op_q.kind == fbpa_pkg::KindFree) ? pool_q : CntW'(idx_q);
  assign mul_p = fbpa_pkg::MulW'(mul_a) * fbpa_pkg::MulW'(stride_eff);

  // Two restoring division steps per cycle
  always_comb begin
    b_hi  = (rem_q >= dsh_q);
    rem_a = b_hi ? (rem_q - dsh_q) : rem_q;
    dsh_b = dsh_q >> 1;
    b_lo  = (rem_a >= dsh_b);
    rem_b = b_lo ? (rem_a - dsh_b) : rem_a;
  end

  assign grant_sum = fbpa_pkg::GrantW'(prod_q) + fbpa_pkg::GrantW'(cfg_i.header_bytes);

  // Result assembly
  always_comb begin
    res_d.status         = status_q;
    res_d.granted_offset = grant_q ? fbpa_pkg::OffW'(grant_sum) : '0;
    res_d.used_blocks    = fbpa_pkg::PoolW'(alloc_q);
    res_d.free_blocks    = (pool_q > alloc_q) ? fbpa_pkg::PoolW'(pool_q - alloc_q) : '0;
    res_d.peak_blocks    = fbpa_pkg::PoolW'(peak_q);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    wm_d        = wm_q;
    alloc_d     = alloc_q;
    peak_d      = peak_q;
    pool_d      = pool_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    op_d        = op_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    status_d    = status_q;
    grant_d     = grant_q;
    op_take_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = '0;

    case (state_q)
      SIdle: begin
        if (op_valid_i) begin
          op_take_o = 1'b1;
          op_d      = op_i;
          grant_d   = 1'b0;
          status_d  = fbpa_pkg::StOk;
          state_d   = SFin;
          case (op_i.kind)
            fbpa_pkg::KindOversize: status_d = fbpa_pkg::StAllocFail;
            fbpa_pkg::KindReset: begin
              pool_d  = pool_sat;
              head_d  = '0;
              wm_d    = '0;
              alloc_d = '0;
            end
            fbpa_pkg::KindFree: state_d = SMul;
            fbpa_pkg::KindAlloc: begin
              if (list_empty) begin
                status_d = fbpa_pkg::StAllocFail;
              end else begin
                idx_d   = head_q;
                grant_d = 1'b1;
                alloc_d = alloc_q + CntW'(1);
                if (alloc_d > peak_q) begin
                  peak_d = alloc_d;
                end
                if (fresh) begin
                  // untouched block: its link is simply the next index
                  head_d    = head_q + IdxW'(1);
                  wm_d      = wm_q + CntW'(1);
                  ram_we    = 1'b1;
                  ram_waddr = head_q;
                  ram_wdata = {1'b1, head_q};
                  state_d   = SMul;
                end else begin
                  state_d = SArd;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Link of a recycled block arrives; pop it and mark the block used
      SArd: begin
        head_d    = ram_rdata[IdxW-1:0];
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {1'b1, ram_rdata[IdxW-1:0]};
        state_d   = SMul;
      end

      SMul: begin
        prod_d  = mul_p;
        state_d = (op_q.kind == fbpa_pkg::KindFree) ? SChk : SFin;
      end

      // Range check against the pool end, then start the divider
      SChk: begin
        if (fbpa_pkg::CmpW'(op_q.offset) >= fbpa_pkg::CmpW'(prod_q)) begin
          status_d = fbpa_pkg::StRange;
          state_d  = SFin;
        end else begin
          rem_d   = fbpa_pkg::RemW'(op_q.offset);
          dsh_d   = fbpa_pkg::RemW'(stride_eff) << (fbpa_pkg::DivSteps - 1);
          quo_d   = '0;
          dcnt_d  = fbpa_pkg::DivCntW'(fbpa_pkg::DivCycles);
          state_d = SDiv;
        end
      end

      SDiv: begin
        rem_d  = rem_b;
        dsh_d  = dsh_q >> 2;
        quo_d  = fbpa_pkg::DivSteps'({quo_q, b_hi, b_lo});
        dcnt_d = dcnt_q - fbpa_pkg::DivCntW'(1);
        if (dcnt_q == fbpa_pkg::DivCntW'(1)) begin
          state_d = SQchk;
        end
      end

      // Offset must sit exactly at a payload start; RAM read goes out here
      SQchk: begin
        if (rem_q != fbpa_pkg::RemW'(cfg_i.header_bytes)) begin
          status_d = fbpa_pkg::StRange;
          state_d  = SFin;
        end else begin
          state_d = SFrd;
        end
      end

      SFrd: begin
        if ((CntW'(quo_idx) < wm_q) && ram_rdata[IdxW]) begin
          ram_we    = 1'b1;
          ram_waddr = quo_idx;
          ram_wdata = {1'b0, head_q};
          head_d    = quo_idx;
          if (alloc_q != '0) begin
            alloc_d = alloc_q - CntW'(1);
          end
        end else begin
          status_d = fbpa_pkg::StDouble;
        end
        state_d = SFin;
      end

      SFin: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      head_q      <= '0;
      wm_q        <= '0;
      alloc_q     <= '0;
      peak_q      <= '0;
      pool_q      <= CntW'(fbpa_pkg::MaxBlocks);
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      wm_q        <= wm_d;
      alloc_q     <= alloc_d;
      peak_q      <= peak_d;
      pool_q      <= pool_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    quo_q    <= quo_d;
    status_q <= status_d;
    grant_q  <= grant_d;
    if ((state_q == SFin) && out_free) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* hw/rtl/fixed_block_pool_allocator_core.sv */
// Top level of the fixed block pool allocator: configuration registers, front and back.
// Depends on fbpa_pkg, fbpa_front, fbpa_back (and fbpa_ram through fbpa_back).
//
// Usage: request items go in through push/full with req_i (command, request_size,
// payload_offset); results come out through empty/pop with res_o, one result per item,
// in order. Configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i),
// to be written only while no item is in flight.
// Steps per item: pool reset, unused commands and failed allocations go straight to
// the result; an allocation of a never-used block runs the offset multiply, a recycled
// block first reads its link from the link RAM; a free runs the pool-end multiply and
// range check, a 2-bit-per-cycle offset divider and a link RAM read-modify-write, and
// stops after the range check if it is rejected at the pool end.
// The back-end sequencer handles one item at a time; a 2-entry queue in the front
// keeps accepting items meanwhile.
// Reset: configuration returns to its defaults and the pool comes up as 1024 free
// blocks at once; block links are tracked by a watermark, so no clearing pass runs.
// When pop is held low the finished result stays on res_o, the sequencer waits,
// and full rises once the front queue holds two items.
`default_nettype none

module fixed_block_pool_allocator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire fbpa_pkg::fbpa_req_t           req_i,
  output logic                               empty,
  input  wire logic                          pop,
  output fbpa_pkg::fbpa_res_t                res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fbpa_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [fbpa_pkg::CfgW-1:0]     cfg_wdata_i
);

  fbpa_pkg::fbpa_cfg_t cfg_q, cfg_d;
  fbpa_pkg::fbpa_op_t  op;
  logic                op_valid;
  logic                op_take;
  logic                out_valid;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        fbpa_pkg::CfgBlockLimit:
          cfg_d.block_limit = cfg_wdata_i[fbpa_pkg::LimitW-1:0];
        fbpa_pkg::CfgBlocksInUse:
          cfg_d.blocks_in_use = cfg_wdata_i[fbpa_pkg::PoolW-1:0];
        fbpa_pkg::CfgHeaderBytes:
          cfg_d.header_bytes = cfg_wdata_i[fbpa_pkg::HdrW-1:0];
        fbpa_pkg::CfgStrideBytes:
          cfg_d.stride_bytes = cfg_wdata_i[fbpa_pkg::StrideW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_limit   <= fbpa_pkg::LimitW'(64);
      cfg_q.blocks_in_use <= fbpa_pkg::PoolW'(1024);
      cfg_q.header_bytes  <= fbpa_pkg::HdrW'(16);
      cfg_q.stride_bytes  <= fbpa_pkg::StrideW'(80);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify items
  fbpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .limit_i    (cfg_q.block_limit),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_take_i  (op_take)
  );

  // Back: free list engine and result register
  fbpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_take_o   (op_take),
    .out_valid_o (out_valid),
    .res_o       (res_o),
    .out_ready_i (pop)
  );

  assign empty = ~out_valid;

endmodule

`default_nettype wire
